@@ rtl/core/ufpp_pkg.sv @@
// Shared types, codes and sizes for the union-find persistence pairing core.
package ufpp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VERTEX_W     = $clog2(MAX_VERTICES);
  localparam int VALUE_W      = 32;
  localparam int HOP_W        = $clog2(MAX_VERTICES + 1);

  localparam logic [HOP_W-1:0] HOP_LIMIT = HOP_W'(MAX_VERTICES);

  typedef logic [VERTEX_W-1:0]       vertex_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_EDGE    = 1'b1;
  localparam logic KIND_PAIR  = 1'b0;
  localparam logic KIND_CYCLE = 1'b1;
  localparam logic DIR_UP     = 1'b0;
  localparam logic DIR_DOWN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VAL_A,
    ST_VAL_B,
    ST_CHECK,
    ST_HALVE,
    ST_VAL_KEEP,
    ST_VAL_GONE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage

@@ rtl/core/union_find_persistence_pairing_core.sv @@
// Top level: sequencer for zero-dimensional persistence pairing by union-find.
//
// Input channel (in_valid/in_stall) carries one transaction per item: op selects
// a vertex load (vertex_id, vertex_value) or an edge (end_a, end_b). Output
// channel (out_valid/out_stall) returns one transaction per edge: kind,
// birth_value, death_value, dying_vertex. Loads give no result.
// A load is written from the idle state, which it does not leave. An edge reads
// both endpoint values through the single value memory port, then walks each
// endpoint to its root through the single parent memory port with path halving:
// a check step finds the root, and each hop adds a check and a halving step. A
// merging edge then reads both root values and links the dying root to the other.
// in_stall is high while an edge is in progress. The result sits in an output
// register; the next item is accepted while it waits, and a new edge holds in
// its last step only if the previous result has still not been taken.
// cfg_wr_en/cfg_wr_data write the direction register (0 up pass, 1 down pass).
// Synchronous reset clears the sequencer, the output valid and direction; the
// value and parent memories are not cleared and must be loaded before use.
module union_find_persistence_pairing_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [ufpp_pkg::VERTEX_W-1:0] vertex_id,
  input  logic signed [ufpp_pkg::VALUE_W-1:0] vertex_value,
  input  logic [ufpp_pkg::VERTEX_W-1:0] end_a,
  input  logic [ufpp_pkg::VERTEX_W-1:0] end_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic signed [ufpp_pkg::VALUE_W-1:0] birth_value,
  output logic signed [ufpp_pkg::VALUE_W-1:0] death_value,
  output logic [ufpp_pkg::VERTEX_W-1:0] dying_vertex
);

  ufpp_pkg::state_t  state, state_next;
  logic              direction;
  ufpp_pkg::vertex_t a_idx, a_idx_next, b_idx, b_idx_next;
  ufpp_pkg::vertex_t t_idx, t_idx_next, ra, ra_next, rb, rb_next;
  logic [ufpp_pkg::HOP_W-1:0] hops, hops_next;
  logic              phase, phase_next;
  ufpp_pkg::value_t  va, va_next, vk, vk_next, edge_value, edge_value_next;
  logic              res_kind, res_kind_next;
  ufpp_pkg::value_t  res_birth, res_birth_next;
  ufpp_pkg::vertex_t res_dying, res_dying_next;
  logic              out_valid_next;
  logic              out_load;

  logic              p_we, v_we;
  ufpp_pkg::vertex_t p_wa, p_wd, p_ra, p_rdata, v_wa, v_ra;
  ufpp_pkg::value_t  v_wd, v_rdata;

  ufpp_pkg::value_t   cmp_x, cmp_y;
  ufpp_pkg::cmp_res_t cmp_res;
  logic               tie, swap;
  ufpp_pkg::vertex_t  gone, keep;

  ufpp_ram #(
    .DEPTH (ufpp_pkg::MAX_VERTICES),
    .WIDTH (ufpp_pkg::VERTEX_W)
  ) u_parent (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_wa),
    .wr_data (p_wd),
    .rd_addr (p_ra),
    .rd_data (p_rdata)
  );

  ufpp_ram #(
    .DEPTH (ufpp_pkg::MAX_VERTICES),
    .WIDTH (ufpp_pkg::VALUE_W)
  ) u_value (
    .clk     (clk),
    .wr_en   (v_we),
    .wr_addr (v_wa),
    .wr_data (v_wd),
    .rd_addr (v_ra),
    .rd_data (v_rdata)
  );

  ufpp_cmp u_cmp (
    .x   (cmp_x),
    .y   (cmp_y),
    .res (cmp_res)
  );

  assign in_stall = (state != ufpp_pkg::ST_IDLE);

  always_comb begin
    state_next      = state;
    a_idx_next      = a_idx;
    b_idx_next      = b_idx;
    t_idx_next      = t_idx;
    ra_next         = ra;
    rb_next         = rb;
    hops_next       = hops;
    phase_next      = phase;
    va_next         = va;
    vk_next         = vk;
    edge_value_next = edge_value;
    res_kind_next   = res_kind;
    res_birth_next  = res_birth;
    res_dying_next  = res_dying;
    out_valid_next  = out_valid & out_stall;
    out_load        = 1'b0;
    p_we            = 1'b0;
    p_wa            = t_idx;
    p_wd            = p_rdata;
    p_ra            = t_idx;
    v_we            = 1'b0;
    v_wa            = vertex_id;
    v_wd            = vertex_value;
    v_ra            = a_idx;
    cmp_x           = va;
    cmp_y           = v_rdata;
    tie             = 1'b0;
    swap            = 1'b0;
    gone            = rb;
    keep            = ra;

    case (state)
      ufpp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (op == ufpp_pkg::OP_LOAD) begin
            v_we = 1'b1;
            p_we = 1'b1;
            p_wa = vertex_id;
            p_wd = vertex_id;
          end else begin
            a_idx_next = end_a;
            b_idx_next = end_b;
            v_ra       = end_a;
            state_next = ufpp_pkg::ST_VAL_A;
          end
        end
      end

      ufpp_pkg::ST_VAL_A: begin
        va_next    = v_rdata;
        v_ra       = b_idx;
        state_next = ufpp_pkg::ST_VAL_B;
      end

      ufpp_pkg::ST_VAL_B: begin
        // edge value: max of endpoints on the up pass, min on the down pass
        if (direction == ufpp_pkg::DIR_UP) begin
          edge_value_next = cmp_res.less ? v_rdata : va;
        end else begin
          edge_value_next = cmp_res.less ? va : v_rdata;
        end
        t_idx_next = a_idx;
        hops_next  = '0;
        phase_next = 1'b0;
        p_ra       = a_idx;
        state_next = ufpp_pkg::ST_CHECK;
      end

      ufpp_pkg::ST_CHECK: begin
        if (p_rdata == t_idx || hops == ufpp_pkg::HOP_LIMIT) begin
          if (!phase) begin
            // root of end_a found, start the walk from end_b
            ra_next    = t_idx;
            t_idx_next = b_idx;
            hops_next  = '0;
            phase_next = 1'b1;
            p_ra       = b_idx;
          end else if (t_idx == ra) begin
            res_kind_next  = ufpp_pkg::KIND_CYCLE;
            res_birth_next = '0;
            res_dying_next = '0;
            state_next     = ufpp_pkg::ST_DONE;
          end else begin
            rb_next    = t_idx;
            v_ra       = ra;
            state_next = ufpp_pkg::ST_VAL_KEEP;
          end
        end else begin
          p_ra       = p_rdata;
          state_next = ufpp_pkg::ST_HALVE;
        end
      end

      ufpp_pkg::ST_HALVE: begin
        // link t to its grandparent and advance to it
        p_we       = 1'b1;
        p_wa       = t_idx;
        p_wd       = p_rdata;
        t_idx_next = p_rdata;
        hops_next  = hops + 1'b1;
        p_ra       = p_rdata;
        state_next = ufpp_pkg::ST_CHECK;
      end

      ufpp_pkg::ST_VAL_KEEP: begin
        vk_next    = v_rdata;
        v_ra       = rb;
        state_next = ufpp_pkg::ST_VAL_GONE;
      end

      ufpp_pkg::ST_VAL_GONE: begin
        // vk holds the value of ra, v_rdata the value of rb
        if (direction == ufpp_pkg::DIR_UP) begin
          cmp_x = v_rdata;
          cmp_y = vk;
          tie   = (ra > rb);
        end else begin
          cmp_x = vk;
          cmp_y = v_rdata;
          tie   = (ra < rb);
        end
        swap           = cmp_res.less | (cmp_res.equal & tie);
        gone           = swap ? ra : rb;
        keep           = swap ? rb : ra;
        p_we           = 1'b1;
        p_wa           = gone;
        p_wd           = keep;
        res_kind_next  = ufpp_pkg::KIND_PAIR;
        res_birth_next = swap ? vk : v_rdata;
        res_dying_next = gone;
        state_next     = ufpp_pkg::ST_DONE;
      end

      ufpp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ufpp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ufpp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ufpp_pkg::ST_IDLE;
      out_valid <= 1'b0;
      direction <= ufpp_pkg::DIR_UP;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        direction <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx      <= a_idx_next;
    b_idx      <= b_idx_next;
    t_idx      <= t_idx_next;
    ra         <= ra_next;
    rb         <= rb_next;
    hops       <= hops_next;
    phase      <= phase_next;
    va         <= va_next;
    vk         <= vk_next;
    edge_value <= edge_value_next;
    res_kind   <= res_kind_next;
    res_birth  <= res_birth_next;
    res_dying  <= res_dying_next;
    if (out_load) begin
      kind         <= res_kind;
      birth_value  <= res_birth;
      death_value  <= edge_value;
      dying_vertex <= res_dying;
    end
  end

endmodule

@@ rtl/core/ufpp_ram.sv @@
// Single write port, single registered read port memory.
module ufpp_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/ufpp_cmp.sv @@
// Shared signed value comparator used for edge value and survivor choice.
module ufpp_cmp (
  input  ufpp_pkg::value_t   x,
  input  ufpp_pkg::value_t   y,
  output ufpp_pkg::cmp_res_t res
);

  always_comb begin
    res.less  = (x < y);
    res.equal = (x == y);
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench for the union-find persistence pairing core: directed passes plus random scenes.
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_ITEMS = 400;
  localparam int IDLE_SETTLE  = 12;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic              kind;
    ufpp_pkg::value_t  birth;
    ufpp_pkg::value_t  death;
    ufpp_pkg::vertex_t dying;
  } pair_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  logic              cfg_wr_data  = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic              op           = ufpp_pkg::OP_LOAD;
  ufpp_pkg::vertex_t vertex_id    = '0;
  ufpp_pkg::value_t  vertex_value = '0;
  ufpp_pkg::vertex_t end_a        = '0;
  ufpp_pkg::vertex_t end_b        = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              kind;
  ufpp_pkg::value_t  birth_value;
  ufpp_pkg::value_t  death_value;
  ufpp_pkg::vertex_t dying_vertex;

  // Shadow copy of the union-find store and the direction register
  ufpp_pkg::value_t  shadow_value  [ufpp_pkg::MAX_VERTICES];
  ufpp_pkg::vertex_t shadow_parent [ufpp_pkg::MAX_VERTICES];
  bit                vertex_loaded [ufpp_pkg::MAX_VERTICES];
  ufpp_pkg::vertex_t loaded_list[$];
  logic              shadow_dir = ufpp_pkg::DIR_UP;

  pair_t       pairs_due[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          sender_pauses = 1'b1;
  int unsigned cycle_count = 0;

  union_find_persistence_pairing_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .vertex_id    (vertex_id),
    .vertex_value (vertex_value),
    .end_a        (end_a),
    .end_b        (end_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .birth_value  (birth_value),
    .death_value  (death_value),
    .dying_vertex (dying_vertex)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Root search with path halving; rewrites the shadow parent links on the way
  function automatic ufpp_pkg::vertex_t walk_to_root(ufpp_pkg::vertex_t x);
    ufpp_pkg::vertex_t t;
    int                hops;
    t    = x;
    hops = 0;
    while (shadow_parent[t] != t && hops < ufpp_pkg::MAX_VERTICES) begin
      shadow_parent[t] = shadow_parent[shadow_parent[t]];
      t = shadow_parent[t];
      hops++;
    end
    return t;
  endfunction

  function automatic pair_t predict_pairing(ufpp_pkg::vertex_t a, ufpp_pkg::vertex_t b);
    pair_t             r;
    ufpp_pkg::vertex_t ra, rb, keep, gone;
    ufpp_pkg::value_t  va, vb, vk, vg;
    logic              swap;
    va = shadow_value[a];
    vb = shadow_value[b];
    if (shadow_dir == ufpp_pkg::DIR_UP) r.death = (va < vb) ? vb : va;
    else                                r.death = (va < vb) ? va : vb;
    ra = walk_to_root(a);
    rb = walk_to_root(b);
    if (ra == rb) begin
      r.kind  = ufpp_pkg::KIND_CYCLE;
      r.birth = '0;
      r.dying = '0;
      return r;
    end
    keep = ra;
    gone = rb;
    vk   = shadow_value[keep];
    vg   = shadow_value[gone];
    // Elder root survives; ties go to lower index going up, higher going down
    if (shadow_dir == ufpp_pkg::DIR_UP) swap = (vg < vk) || (vk == vg && keep > gone);
    else                                swap = (vk < vg) || (vk == vg && keep < gone);
    if (swap) begin
      keep = rb;
      gone = ra;
    end
    shadow_parent[gone] = keep;
    r.kind  = ufpp_pkg::KIND_PAIR;
    r.birth = shadow_value[gone];
    r.dying = gone;
    return r;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_pauses || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic ufpp_pkg::value_t rand_value();
    case ($urandom_range(0, 9))
      0:          return 32'sh8000_0000;
      1:          return 32'sh7fff_ffff;
      2, 3, 4, 5: return ufpp_pkg::value_t'(($urandom_range(0, 7) - 3) * 65536);
      default:    return ufpp_pkg::value_t'($urandom);
    endcase
  endfunction

  function automatic ufpp_pkg::vertex_t rand_vertex();
    return ufpp_pkg::vertex_t'($urandom_range(0, ufpp_pkg::MAX_VERTICES - 1));
  endfunction

  task automatic send_item(logic op_i, ufpp_pkg::vertex_t idx_i, ufpp_pkg::value_t val_i,
                           ufpp_pkg::vertex_t a_i, ufpp_pkg::vertex_t b_i);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= op_i;
    vertex_id    <= idx_i;
    vertex_value <= val_i;
    end_a        <= a_i;
    end_b        <= b_i;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (op_i == ufpp_pkg::OP_LOAD) begin
      shadow_value[idx_i]  = val_i;
      shadow_parent[idx_i] = idx_i;
      if (!vertex_loaded[idx_i]) loaded_list.insert(loaded_list.size(), idx_i);
      vertex_loaded[idx_i] = 1'b1;
    end else begin
      pairs_due.insert(pairs_due.size(), predict_pairing(a_i, b_i));
    end
  endtask

  task automatic load_vertex(ufpp_pkg::vertex_t idx, ufpp_pkg::value_t val);
    send_item(ufpp_pkg::OP_LOAD, idx, val, rand_vertex(), rand_vertex());
  endtask

  task automatic send_edge(ufpp_pkg::vertex_t a, ufpp_pkg::vertex_t b);
    send_item(ufpp_pkg::OP_EDGE, rand_vertex(), rand_value(), a, b);
  endtask

  // Drop valid, let every pending result drain, then let any trailing load finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic set_direction(logic d);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_dir = d;
  endtask

  task automatic test_up_pass();
    set_direction(ufpp_pkg::DIR_UP);
    load_vertex(10'd0, 32'sh8000_0000);
    load_vertex(10'd1023, 32'sh7fff_ffff);
    load_vertex(10'd1, 32'sh0000_0000);
    load_vertex(10'd2, 32'sh0000_0000);
    load_vertex(10'd512, 32'shffff_ffff);
    load_vertex(10'd3, 32'sh0001_0000);
    send_edge(10'd0, 10'd0);      // self loop
    send_edge(10'd1, 10'd2);      // equal values, lower index survives
    send_edge(10'd2, 10'd1);      // cycle edge
    send_edge(10'd1023, 10'd0);
    send_edge(10'd512, 10'd1);
    send_edge(10'd0, 10'd512);
    send_edge(10'd3, 10'd1023);
    send_edge(10'd2, 10'd3);      // cycle through longer walks
    wait_idle();
  endtask

  task automatic test_down_pass();
    set_direction(ufpp_pkg::DIR_DOWN);
    load_vertex(10'd10, 32'sh0000_0005);
    load_vertex(10'd11, 32'sh0000_0005);
    load_vertex(10'd12, 32'sh7fff_ffff);
    load_vertex(10'd13, 32'sh8000_0000);
    send_edge(10'd10, 10'd11);    // equal values, higher index survives
    send_edge(10'd13, 10'd12);
    send_edge(10'd11, 10'd12);
    send_edge(10'd13, 10'd10);    // cycle edge
    wait_idle();
  endtask

  // One scene: load a vertex set, then edges over it with a little noise mixed in
  task automatic run_scene();
    ufpp_pkg::vertex_t members[$];
    ufpp_pkg::vertex_t a;
    int                n;
    int                n_edges;
    n = $urandom_range(2, 40);
    repeat (n) begin
      a = rand_vertex();
      members.insert(members.size(), a);
      load_vertex(a, rand_value());
    end
    n_edges = n + $urandom_range(0, n);
    repeat (n_edges) begin
      case ($urandom_range(0, 19))
        0: load_vertex(members[$urandom_range(0, members.size() - 1)], rand_value());
        1: begin
          a = members[$urandom_range(0, members.size() - 1)];
          send_edge(a, a);
        end
        2: send_edge(loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                     loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        default: send_edge(members[$urandom_range(0, members.size() - 1)],
                           members[$urandom_range(0, members.size() - 1)]);
      endcase
    end
  endtask

  task automatic test_random_scenes();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      wait_idle();
      set_direction(logic'($urandom_range(0, 1)));
      sender_pauses = ($urandom_range(0, 3) != 0);
      run_scene();
    end
    wait_idle();
  endtask

  // Receiver back-pressure: free stretches, some long, between short or long stalls
  initial begin : stall_gen
    int free_len;
    int stall_len;
    @(posedge clk);
    forever begin
      free_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 6);
      stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_pairs
    pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pairs_due.size() == 0) begin
        $error("result transaction with no pending expectation");
        errors++;
      end else begin
        want = pairs_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (birth_value !== want.birth) begin
          $error("birth_value: expected 'h%08h, actual 'h%08h", want.birth, birth_value);
          errors++;
        end
        if (death_value !== want.death) begin
          $error("death_value: expected 'h%08h, actual 'h%08h", want.death, death_value);
          errors++;
        end
        if (dying_vertex !== want.dying) begin
          $error("dying_vertex: expected %0d, actual %0d", want.dying, dying_vertex);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_up_pass();
    test_down_pass();
    test_random_scenes();
    if (pairs_due.size() != 0) begin
      $error("%0d expected results never arrived", pairs_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ufpp_pkg.sv
rtl/core/ufpp_ram.sv
rtl/core/ufpp_cmp.sv
rtl/core/union_find_persistence_pairing_core.sv
dv/tb_top.sv
